/* hw/rtl/slbw_pkg.sv */
// Package for the semi-Lagrangian backtrace weights unit.
// Holds grid sizes, field widths, the queue record, state types and helpers.
// Depends on nothing; every other file of the block uses it.
package slbw_pkg;

    localparam int SIZE_X = 64;
    localparam int SIZE_Y = 64;
    localparam int SIZE_Z = 64;

    localparam int CELL_W      = 6;
    localparam int VEL_W       = 32;
    localparam int CFG_W       = 31;
    localparam int CFG_INDEX_W = 1;
    localparam int IDX_W       = 18;
    localparam int WEIGHT_W    = 17;
    localparam int NODE_W      = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0] GRID_SPACING_RST = 31'd65536;
    localparam logic [CFG_W-1:0] TIME_STEP_RST    = 31'd6554;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE    = 17'd65536;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRID_SPACING = 1'b0,
        REG_TIME_STEP    = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_OUTSIDE,
        KIND_EXACT,
        KIND_NORMAL
    } kind_t;

    typedef struct packed {
        kind_t                       kind;
        logic [2:0][NODE_W-1:0]      node;
        logic [2:0][CFG_W-1:0]       gap;
    } rec_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_SRC,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SINGLE,
        B_SQ,
        B_SUM,
        B_SQRT,
        B_RECIP_INIT,
        B_INV,
        B_STORE,
        B_NLOAD,
        B_NORM,
        B_EMIT
    } back_state_t;

    // Neighbour order: base, x-1, y-1, z-1, xy, yz, xz, xyz.
    function automatic logic [2:0] mask_order(input logic [2:0] k);
        logic [2:0] m;
        case (k)
            3'd0: m = 3'd0;
            3'd1: m = 3'd1;
            3'd2: m = 3'd2;
            3'd3: m = 3'd4;
            3'd4: m = 3'd3;
            3'd5: m = 3'd6;
            3'd6: m = 3'd5;
            default: m = 3'd7;
        endcase
        return m;
    endfunction

    function automatic logic [IDX_W-1:0] lin_index(input logic [NODE_W-1:0] px,
                                                   input logic [NODE_W-1:0] py,
                                                   input logic [NODE_W-1:0] pz);
        logic [IDX_W-1:0] iy;
        logic [IDX_W-1:0] iz;
        iy = IDX_W'(IDX_W'(py) * IDX_W'(SIZE_X));
        iz = IDX_W'(IDX_W'(pz) * IDX_W'(SIZE_X * SIZE_Y));
        return IDX_W'(IDX_W'(px) + iy + iz);
    endfunction

endpackage

/* hw/rtl/slbw_if.sv */
// Channel interfaces of the backtrace weights unit: input item, result item
// and configuration write. Depends on slbw_pkg for the field widths.
interface slbw_item_if;
    logic                         valid;
    logic                         ready;
    logic [slbw_pkg::CELL_W-1:0]  cell_x;
    logic [slbw_pkg::CELL_W-1:0]  cell_y;
    logic [slbw_pkg::CELL_W-1:0]  cell_z;
    logic [slbw_pkg::VEL_W-1:0]   vel_x;
    logic [slbw_pkg::VEL_W-1:0]   vel_y;
    logic [slbw_pkg::VEL_W-1:0]   vel_z;
    modport source (output valid, cell_x, cell_y, cell_z, vel_x, vel_y, vel_z,
                    input ready);
    modport sink (input valid, cell_x, cell_y, cell_z, vel_x, vel_y, vel_z,
                  output ready);
endinterface

interface slbw_result_if;
    logic                           valid;
    logic                           ready;
    logic [slbw_pkg::IDX_W-1:0]     neighbour_index;
    logic [slbw_pkg::WEIGHT_W-1:0]  weight;
    logic                           outside_grid;
    logic                           last;
    modport source (output valid, neighbour_index, weight, outside_grid, last,
                    input ready);
    modport sink (input valid, neighbour_index, weight, outside_grid, last,
                  output ready);
endinterface

interface slbw_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [slbw_pkg::CFG_INDEX_W-1:0]  index;
    logic [slbw_pkg::CFG_W-1:0]        data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/slbw_front.sv */
// Front end of the backtrace weights unit: takes an item, traces it back,
// finds upper nodes and distances, classifies it. Depends on slbw_pkg, slbw_if.
module slbw_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [slbw_pkg::CFG_W-1:0]     grid_spacing,
    input  logic [slbw_pkg::CFG_W-1:0]     time_step,
    slbw_item_if.sink                      item,
    output slbw_pkg::rec_t                 rec,
    output logic                           push,
    input  logic                           full
);

    slbw_pkg::front_state_t state_reg;
    slbw_pkg::front_state_t state_next;

    logic [2:0][slbw_pkg::CELL_W-1:0] cell_reg;
    logic [2:0][slbw_pkg::VEL_W-1:0]  vel_reg;
    logic signed [63:0]               prod_reg [3];
    logic [36:0]                      cg_reg [3];
    logic [38:0]                      top_reg [3];
    logic                             outside_reg;
    logic [39:0]                      rem_reg [3];
    logic [slbw_pkg::NODE_W-1:0]      q_reg [3];
    logic [2:0]                       cnt_reg;

    logic [8:0]                       size_m1 [3];
    logic signed [63:0]               rnd [3];
    logic signed [48:0]               src [3];
    logic [2:0]                       out_axis;
    logic [39:0]                      dv [3];
    logic [slbw_pkg::CFG_W-1:0]       gap [3];
    logic                             accept;

    assign accept = item.valid && item.ready;
    assign item.ready = (state_reg == slbw_pkg::F_IDLE) ||
                        (state_reg == slbw_pkg::F_PUSH && !full);

    always_comb
    begin
        size_m1[0] = 9'(slbw_pkg::SIZE_X - 1);
        size_m1[1] = 9'(slbw_pkg::SIZE_Y - 1);
        size_m1[2] = 9'(slbw_pkg::SIZE_Z - 1);
        for (int a = 0; a < 3; a++)
        begin
            rnd[a] = (prod_reg[a] + 64'sd32768) >>> 16;
            src[a] = $signed({12'd0, cg_reg[a]}) - $signed(rnd[a][48:0]);
            out_axis[a] = (src[a] <= 49'sd0) || ($unsigned(src[a]) >= 49'(top_reg[a]));
            dv[a] = 40'(grid_spacing) << cnt_reg;
            gap[a] = grid_spacing - 31'd1 - rem_reg[a][30:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            slbw_pkg::F_IDLE:
            begin
                if (item.valid)
                    state_next = slbw_pkg::F_MUL;
            end
            slbw_pkg::F_MUL:  state_next = slbw_pkg::F_SRC;
            slbw_pkg::F_SRC:  state_next = slbw_pkg::F_DIV;
            slbw_pkg::F_DIV:
            begin
                if (cnt_reg == 3'd0)
                    state_next = slbw_pkg::F_PUSH;
            end
            slbw_pkg::F_PUSH:
            begin
                if (!full)
                    state_next = item.valid ? slbw_pkg::F_MUL : slbw_pkg::F_IDLE;
            end
            default: state_next = slbw_pkg::F_IDLE;
        endcase
    end

    always_comb
    begin
        push = (state_reg == slbw_pkg::F_PUSH) && !full;
        for (int a = 0; a < 3; a++)
        begin
            rec.node[a] = q_reg[a] + 8'd1;
            rec.gap[a] = gap[a];
        end
        if (outside_reg)
            rec.kind = slbw_pkg::KIND_OUTSIDE;
        else if (gap[0] == '0 && gap[1] == '0 && gap[2] == '0)
            rec.kind = slbw_pkg::KIND_EXACT;
        else
            rec.kind = slbw_pkg::KIND_NORMAL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= slbw_pkg::F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cell_reg <= {item.cell_z, item.cell_y, item.cell_x};
            vel_reg  <= {item.vel_z, item.vel_y, item.vel_x};
        end
        case (state_reg)
            slbw_pkg::F_MUL:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    prod_reg[a] <= $signed(vel_reg[a]) * $signed({1'b0, time_step});
                    cg_reg[a]   <= 37'(cell_reg[a]) * 37'(grid_spacing);
                    top_reg[a]  <= 39'(size_m1[a]) * 39'(grid_spacing);
                end
            end
            slbw_pkg::F_SRC:
            begin
                outside_reg <= |out_axis;
                cnt_reg <= 3'd7;
                for (int a = 0; a < 3; a++)
                begin
                    rem_reg[a] <= src[a][39:0] - 40'd1;
                    q_reg[a]   <= '0;
                end
            end
            slbw_pkg::F_DIV:
            begin
                cnt_reg <= cnt_reg - 3'd1;
                for (int a = 0; a < 3; a++)
                begin
                    if (rem_reg[a] >= dv[a])
                    begin
                        rem_reg[a] <= rem_reg[a] - dv[a];
                        q_reg[a][cnt_reg] <= 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    a_dist_below_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == slbw_pkg::F_PUSH && !outside_reg) |->
        (rem_reg[0] < 40'(grid_spacing) && rem_reg[1] < 40'(grid_spacing) &&
         rem_reg[2] < 40'(grid_spacing)))
        else $error("Node remainder not below the grid spacing.");

endmodule

/* hw/rtl/slbw_queue.sv */
// Short record queue between the front and back ends.
// Depends on slbw_pkg for the record type and depth.
module slbw_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  slbw_pkg::rec_t  wr_rec,
    input  logic            push,
    output logic            full,
    output slbw_pkg::rec_t  rd_rec,
    output logic            rd_valid,
    input  logic            pop
);

    slbw_pkg::rec_t                        entry_reg [slbw_pkg::QUEUE_DEPTH];
    logic [slbw_pkg::QUEUE_PTR_W-1:0]      wr_ptr_reg;
    logic [slbw_pkg::QUEUE_PTR_W-1:0]      rd_ptr_reg;
    logic [slbw_pkg::QUEUE_CNT_W-1:0]      cnt_reg;

    assign full     = (cnt_reg == slbw_pkg::QUEUE_CNT_W'(slbw_pkg::QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_rec   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_rec;
    end

endmodule

/* hw/rtl/slbw_back.sv */
// Back end of the backtrace weights unit: distances, square roots,
// inverses and normalized weights, one result item at a time.
// Depends on slbw_pkg and slbw_if.
module slbw_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [slbw_pkg::CFG_W-1:0]  grid_spacing,
    input  slbw_pkg::rec_t              rec,
    input  logic                        rec_valid,
    output logic                        pop,
    slbw_result_if.source               result
);

    slbw_pkg::back_state_t state_reg;
    slbw_pkg::back_state_t state_next;

    slbw_pkg::rec_t                 rec_reg;
    logic [2:0]                     k_reg;
    logic [3:0]                     n_reg;
    logic [2:0]                     j_reg;
    logic [61:0]                    sq_reg [3];
    logic [slbw_pkg::IDX_W-1:0]     pos_idx_reg;
    logic [63:0]                    rad_reg;
    logic [63:0]                    root_reg;
    logic [63:0]                    bit_reg;
    logic [5:0]                     cnt_reg;
    logic [31:0]                    div_reg;
    logic [31:0]                    drem_reg;
    logic [58:0]                    quo_reg;
    logic [58:0]                    inv_reg [8];
    logic [slbw_pkg::IDX_W-1:0]     idx_reg [8];
    logic [61:0]                    sum_reg;
    logic [61:0]                    nrem_reg;
    logic [16:0]                    nq_reg;

    logic                           out_valid_reg;
    logic [slbw_pkg::IDX_W-1:0]     out_idx_reg;
    logic [slbw_pkg::WEIGHT_W-1:0]  out_weight_reg;
    logic                           out_outside_reg;
    logic                           out_last_reg;

    logic                           slot_free;
    logic                           out_load;
    logic [2:0]                     m;
    logic                           use_nb;
    logic [slbw_pkg::CFG_W-1:0]     d [3];
    logic [slbw_pkg::NODE_W-1:0]    p [3];
    logic [63:0]                    sq_try;
    logic                           sq_ge;
    logic [32:0]                    dsh;
    logic                           d_ge;
    logic [62:0]                    nsh;
    logic                           n_ge;
    logic [17:0]                    wround;
    logic                           emit_last;

    assign slot_free = !out_valid_reg || result.ready;

    always_comb
    begin
        m = slbw_pkg::mask_order(k_reg);
        use_nb = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if (m[a])
            begin
                d[a] = grid_spacing - rec_reg.gap[a];
                p[a] = rec_reg.node[a] - 8'd1;
                if (rec_reg.gap[a] == '0)
                    use_nb = 1'b0;
            end
            else
            begin
                d[a] = rec_reg.gap[a];
                p[a] = rec_reg.node[a];
            end
        end
        sq_try = root_reg + bit_reg;
        sq_ge  = rad_reg >= sq_try;
        dsh    = {drem_reg, (cnt_reg == 6'd58)};
        d_ge   = dsh >= {1'b0, div_reg};
        nsh    = {nrem_reg, 1'b0};
        n_ge   = nsh >= {1'b0, sum_reg};
        wround = {1'b0, nq_reg} + 18'd1;
        emit_last = ({1'b0, j_reg} + 4'd1) == n_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            slbw_pkg::B_IDLE:
            begin
                if (rec_valid)
                    state_next = (rec.kind == slbw_pkg::KIND_NORMAL) ?
                                 slbw_pkg::B_SQ : slbw_pkg::B_SINGLE;
            end
            slbw_pkg::B_SINGLE:
            begin
                if (slot_free)
                    state_next = slbw_pkg::B_IDLE;
            end
            slbw_pkg::B_SQ:
            begin
                if (use_nb)
                    state_next = slbw_pkg::B_SUM;
                else if (k_reg == 3'd7)
                    state_next = slbw_pkg::B_NLOAD;
            end
            slbw_pkg::B_SUM: state_next = slbw_pkg::B_SQRT;
            slbw_pkg::B_SQRT:
            begin
                if (cnt_reg == 6'd31)
                    state_next = slbw_pkg::B_RECIP_INIT;
            end
            slbw_pkg::B_RECIP_INIT: state_next = slbw_pkg::B_INV;
            slbw_pkg::B_INV:
            begin
                if (cnt_reg == 6'd0)
                    state_next = slbw_pkg::B_STORE;
            end
            slbw_pkg::B_STORE:
                state_next = (k_reg == 3'd7) ? slbw_pkg::B_NLOAD : slbw_pkg::B_SQ;
            slbw_pkg::B_NLOAD: state_next = slbw_pkg::B_NORM;
            slbw_pkg::B_NORM:
            begin
                if (cnt_reg == 6'd16)
                    state_next = slbw_pkg::B_EMIT;
            end
            slbw_pkg::B_EMIT:
            begin
                if (slot_free)
                    state_next = emit_last ? slbw_pkg::B_IDLE : slbw_pkg::B_NLOAD;
            end
            default: state_next = slbw_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        pop = (state_reg == slbw_pkg::B_IDLE) && rec_valid;
        out_load = ((state_reg == slbw_pkg::B_SINGLE) ||
                    (state_reg == slbw_pkg::B_EMIT)) && slot_free;
    end

    assign result.valid           = out_valid_reg;
    assign result.neighbour_index = out_idx_reg;
    assign result.weight          = out_weight_reg;
    assign result.outside_grid    = out_outside_reg;
    assign result.last            = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slbw_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (state_reg == slbw_pkg::B_EMIT)
            begin
                out_idx_reg     <= idx_reg[j_reg];
                out_weight_reg  <= wround[17:1];
                out_outside_reg <= 1'b0;
                out_last_reg    <= emit_last;
            end
            else if (rec_reg.kind == slbw_pkg::KIND_OUTSIDE)
            begin
                out_idx_reg     <= '0;
                out_weight_reg  <= '0;
                out_outside_reg <= 1'b1;
                out_last_reg    <= 1'b1;
            end
            else
            begin
                out_idx_reg     <= slbw_pkg::lin_index(rec_reg.node[0], rec_reg.node[1],
                                                       rec_reg.node[2]);
                out_weight_reg  <= slbw_pkg::WEIGHT_ONE;
                out_outside_reg <= 1'b0;
                out_last_reg    <= 1'b1;
            end
        end
        case (state_reg)
            slbw_pkg::B_IDLE:
            begin
                if (rec_valid)
                begin
                    rec_reg <= rec;
                    k_reg   <= '0;
                    n_reg   <= '0;
                    j_reg   <= '0;
                    sum_reg <= '0;
                end
            end
            slbw_pkg::B_SQ:
            begin
                if (use_nb)
                begin
                    for (int a = 0; a < 3; a++)
                        sq_reg[a] <= 62'(d[a]) * 62'(d[a]);
                    pos_idx_reg <= slbw_pkg::lin_index(p[0], p[1], p[2]);
                end
                else
                    k_reg <= k_reg + 3'd1;
            end
            slbw_pkg::B_SUM:
            begin
                rad_reg  <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
                root_reg <= '0;
                bit_reg  <= 64'd1 << 62;
                cnt_reg  <= '0;
            end
            slbw_pkg::B_SQRT:
            begin
                if (sq_ge)
                begin
                    rad_reg  <= rad_reg - sq_try;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 6'd1;
            end
            slbw_pkg::B_RECIP_INIT:
            begin
                div_reg  <= (root_reg == '0) ? 32'd1 : root_reg[31:0];
                drem_reg <= '0;
                quo_reg  <= '0;
                cnt_reg  <= 6'd58;
            end
            slbw_pkg::B_INV:
            begin
                drem_reg <= d_ge ? 32'(dsh - {1'b0, div_reg}) : dsh[31:0];
                quo_reg  <= {quo_reg[57:0], d_ge};
                cnt_reg  <= cnt_reg - 6'd1;
            end
            slbw_pkg::B_STORE:
            begin
                inv_reg[n_reg[2:0]] <= quo_reg;
                idx_reg[n_reg[2:0]] <= pos_idx_reg;
                sum_reg <= sum_reg + 62'(quo_reg);
                n_reg   <= n_reg + 4'd1;
                k_reg   <= k_reg + 3'd1;
            end
            slbw_pkg::B_NLOAD:
            begin
                nrem_reg <= 62'(inv_reg[j_reg]);
                nq_reg   <= '0;
                cnt_reg  <= '0;
            end
            slbw_pkg::B_NORM:
            begin
                nrem_reg <= n_ge ? 62'(nsh - {1'b0, sum_reg}) : nsh[61:0];
                nq_reg   <= {nq_reg[15:0], n_ge};
                cnt_reg  <= cnt_reg + 6'd1;
            end
            slbw_pkg::B_EMIT:
            begin
                if (slot_free)
                    j_reg <= j_reg + 3'd1;
            end
            default:
            begin
            end
        endcase
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == slbw_pkg::B_NLOAD) |-> (n_reg != 4'd0 && n_reg <= 4'd8))
        else $error("Neighbour count out of range at normalization.");

    a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == slbw_pkg::B_RECIP_INIT) |-> (root_reg[63:32] == '0))
        else $error("Square root wider than the divisor.");

    a_norm_rem_below_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == slbw_pkg::B_NORM && cnt_reg != 6'd0) |-> (nrem_reg < sum_reg))
        else $error("Normalization remainder not below the sum of inverses.");

endmodule

/* hw/rtl/semi_lagrangian_backtrace_weights_unit.sv */
// Top level of the semi-Lagrangian backtrace weights unit.
// Holds the configuration registers and joins front end, queue and back end.
// Depends on slbw_pkg, slbw_if, slbw_front, slbw_queue and slbw_back.
//
// Use: each item on the item channel is one grid cell and its velocity. The
// unit answers with one result item for a source outside the grid or on a
// node, otherwise with one result per usable neighbour (up to eight), the
// final one marked by last. The cfg channel writes grid_spacing (index 0)
// and time_step (index 1); it is always ready. It must be written only
// while the unit is idle; the block itself does not enforce this. The
// front end does three multiplies and an 8-step node division per item
// and may start the next item as it hands one on. The back end runs each
// neighbour through its shared 32-step square root and 59-step reciprocal,
// then each result through the 17-step normalizing divider. A two-entry
// queue lets the front end run ahead. Results sit in an output register; a
// stall holds it and the back end waits. Reset clears all control state and
// loads the register defaults; no clearing pass is needed.
module semi_lagrangian_backtrace_weights_unit (
    input  logic             clk,
    input  logic             rst_n,
    slbw_cfg_if.sink         cfg,
    slbw_item_if.sink        item,
    slbw_result_if.source    result
);

    logic [slbw_pkg::CFG_W-1:0] grid_spacing_reg;
    logic [slbw_pkg::CFG_W-1:0] time_step_reg;

    slbw_pkg::rec_t front_rec;
    slbw_pkg::rec_t queue_rec;
    logic           push;
    logic           full;
    logic           queue_valid;
    logic           pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_spacing_reg <= slbw_pkg::GRID_SPACING_RST;
            time_step_reg    <= slbw_pkg::TIME_STEP_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                slbw_pkg::REG_GRID_SPACING: grid_spacing_reg <= cfg.data;
                slbw_pkg::REG_TIME_STEP:    time_step_reg    <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    slbw_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .grid_spacing (grid_spacing_reg),
        .time_step    (time_step_reg),
        .item         (item),
        .rec          (front_rec),
        .push         (push),
        .full         (full)
    );

    slbw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_rec   (front_rec),
        .push     (push),
        .full     (full),
        .rd_rec   (queue_rec),
        .rd_valid (queue_valid),
        .pop      (pop)
    );

    slbw_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .grid_spacing (grid_spacing_reg),
        .rec          (queue_rec),
        .rec_valid    (queue_valid),
        .pop          (pop),
        .result       (result)
    );

endmodule

/* dv/tb.sv */
// Testbench for semi_lagrangian_backtrace_weights_unit: directed and random cells checked
// against a bit-exact predictor of the backtrace, neighbour order and weights.
// Depends on slbw_pkg, the slbw_if interfaces and the RTL of the unit.
`timescale 1ns / 100ps

module tb;
    import slbw_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]    index;
        logic [WEIGHT_W-1:0] weight;
        logic                outside;
        logic                last;
    } weight_item_t;

    localparam int STALL_LIMIT = 8000;

    logic clk;
    logic rst_n;
    logic idle_en;
    int   errors;
    int   quiet_cycles;
    int   rx_stall;
    bit [63:0] spacing_q;
    bit [63:0] step_q;
    weight_item_t pending_weights[$];

    slbw_cfg_if    cfg_if ();
    slbw_item_if   item_if ();
    slbw_result_if res_if ();

    semi_lagrangian_backtrace_weights_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .item   (item_if),
        .result (res_if)
    );

    always #4 clk = ~clk;

    function automatic bit [63:0] int_sqrt(input bit [63:0] n_in);
        bit [63:0] n;
        bit [63:0] res;
        bit [63:0] b;
        n = n_in;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint source_pos(input logic [CELL_W-1:0] c, input logic [VEL_W-1:0] v);
        longint prod;
        longint p;
        prod = longint'($signed(v)) * longint'(step_q) + 64'sd32768;
        if (prod >= 0)
            p = prod / 65536;
        else
            p = -((-prod + 65535) / 65536);
        return longint'(c) * longint'(spacing_q) - p;
    endfunction

    function automatic void add_expected(input weight_item_t w);
        pending_weights.insert(pending_weights.size(), w);
    endfunction

    task automatic predict_weights(input logic [CELL_W-1:0] c[3], input logic [VEL_W-1:0] v[3]);
        bit [63:0] node[3];
        bit [63:0] gap[3];
        bit [63:0] inv[8];
        bit [IDX_W-1:0] idx[8];
        bit [63:0] sum;
        bit [63:0] top;
        bit [63:0] s;
        bit [63:0] sq;
        bit [63:0] d;
        bit [63:0] pos[3];
        bit [63:0] r;
        bit [63:0] rem;
        bit [63:0] q;
        bit [2:0] m;
        longint src;
        bit ok;
        bit usable;
        int n;
        int sizes[3];
        weight_item_t w;
        sizes = '{SIZE_X, SIZE_Y, SIZE_Z};
        ok = 1;
        sum = 0;
        n = 0;
        for (int a = 0; a < 3; a++)
        begin
            src = source_pos(c[a], v[a]);
            top = 64'(sizes[a] - 1) * spacing_q;
            node[a] = 0;
            gap[a] = 0;
            if (src <= 0 || 64'(src) >= top)
                ok = 0;
            else
            begin
                s = 64'(src);
                node[a] = (s + spacing_q - 1) / spacing_q;
                gap[a] = node[a] * spacing_q - s;
            end
        end
        if (!ok)
        begin
            w = '{index: '0, weight: '0, outside: 1'b1, last: 1'b1};
            add_expected(w);
            return;
        end
        if (gap[0] == 0 && gap[1] == 0 && gap[2] == 0)
        begin
            w.index = IDX_W'(node[0] + node[1] * SIZE_X + node[2] * SIZE_X * SIZE_Y);
            w.weight = WEIGHT_ONE;
            w.outside = 1'b0;
            w.last = 1'b1;
            add_expected(w);
            return;
        end
        for (int k = 0; k < 8; k++)
        begin
            m = mask_order(3'(k));
            sq = 0;
            usable = 1;
            for (int a = 0; a < 3; a++)
            begin
                d = gap[a];
                pos[a] = node[a];
                if (m[a])
                begin
                    if (gap[a] == 0)
                        usable = 0;
                    d = spacing_q - gap[a];
                    pos[a] = node[a] - 1;
                end
                sq = sq + d * d;
            end
            if (usable)
            begin
                idx[n] = IDX_W'(pos[0] + pos[1] * SIZE_X + pos[2] * SIZE_X * SIZE_Y);
                r = int_sqrt(sq);
                if (r == 0)
                    r = 1;
                inv[n] = (64'd1 << 58) / r;
                sum = sum + inv[n];
                n++;
            end
        end
        for (int k = 0; k < n; k++)
        begin
            rem = inv[k];
            q = 0;
            for (int b = 0; b < 17; b++)
            begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= sum)
                begin
                    rem = rem - sum;
                    q[0] = 1'b1;
                end
            end
            w.index = idx[k];
            w.weight = WEIGHT_W'((q + 1) >> 1);
            w.outside = 1'b0;
            w.last = (k == n - 1);
            add_expected(w);
        end
    endtask

    task automatic idle_gap();
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic send_cell(input logic [CELL_W-1:0] c[3], input logic [VEL_W-1:0] v[3]);
        idle_gap();
        item_if.valid  <= 1'b1;
        item_if.cell_x <= c[0];
        item_if.cell_y <= c[1];
        item_if.cell_z <= c[2];
        item_if.vel_x  <= v[0];
        item_if.vel_y  <= v[1];
        item_if.vel_z  <= v[2];
        do
            @(posedge clk);
        while (!item_if.ready);
        predict_weights(c, v);
    endtask

    task automatic send_one(input int cx, input int cy, input int cz,
                            input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz);
        logic [CELL_W-1:0] c[3];
        logic [VEL_W-1:0] v[3];
        c = '{CELL_W'(cx), CELL_W'(cy), CELL_W'(cz)};
        v = '{vx, vy, vz};
        send_cell(c, v);
    endtask

    task automatic drain();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_weights.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= r;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (r == REG_GRID_SPACING)
            spacing_q = 64'(value);
        else
            step_q = 64'(value);
        @(posedge clk);
    endtask

    function automatic logic [VEL_W-1:0] pick_vel(input bit well_formed);
        longint off;
        longint vel;
        if (!well_formed)
            return $urandom;
        if ($urandom_range(0, 4) == 0)
            return '0;
        off = longint'($urandom_range(0, int'(spacing_q > 64'h7fffffff ? 64'h7fffffff : spacing_q)));
        if ($urandom_range(0, 1))
            off = -off;
        if (step_q == 0)
            return $urandom;
        vel = off * 65536 / longint'(step_q);
        if (vel > 64'sh7fffffff)
            vel = 64'sh7fffffff;
        if (vel < -64'sh80000000)
            vel = -64'sh80000000;
        return VEL_W'(vel);
    endfunction

    task automatic send_random(input int count);
        logic [CELL_W-1:0] c[3];
        logic [VEL_W-1:0] v[3];
        bit well;
        for (int i = 0; i < count; i++)
        begin
            well = ($urandom_range(0, 3) != 0);
            for (int a = 0; a < 3; a++)
            begin
                c[a] = well ? CELL_W'($urandom_range(1, 62)) : CELL_W'($urandom_range(0, 63));
                v[a] = pick_vel(well);
            end
            send_cell(c, v);
        end
    endtask

    task automatic test_reset_defaults();
        send_one(10, 20, 30, 32'h0, 32'h0, 32'h0);
        send_one(1, 1, 1, 32'h0000_8000, 32'h0, 32'h0);
        send_one(5, 5, 5, 32'h0000_8000, 32'hFFFF_8000, 32'h0);
        send_one(5, 6, 7, 32'h0001_2345, 32'hFFFE_0000, 32'h0004_0000);
        send_one(62, 62, 62, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
        send_one(0, 10, 10, 32'h0001_0000, 32'h0, 32'h0);
        send_one(0, 10, 10, 32'hFFFF_0000, 32'h0, 32'h0);
        send_one(63, 10, 10, 32'h0, 32'h0, 32'h0);
        send_one(63, 63, 63, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_one(30, 30, 30, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        send_one(30, 30, 30, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_one(30, 31, 32, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0005);
        send_one(63, 0, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        drain();
    endtask

    task automatic test_unit_step();
        write_reg(REG_TIME_STEP, 31'd65536);
        send_one(20, 20, 20, 32'h0000_4000, 32'h0000_C000, 32'hFFFF_2000);
        send_one(62, 1, 33, 32'h0000_8000, 32'h0000_0001, 32'h0);
        send_random(25);
        drain();
    endtask

    task automatic test_extreme_registers();
        write_reg(REG_GRID_SPACING, 31'h7FFF_FFFF);
        write_reg(REG_TIME_STEP, 31'h7FFF_FFFF);
        send_one(31, 31, 31, 32'h1234_5678, 32'hEDCB_A988, 32'h0000_0000);
        send_one(1, 62, 40, 32'h4000_0000, 32'hC000_0000, 32'h7FFF_FFFF);
        send_random(20);
        drain();
    endtask

    task automatic test_zero_step();
        write_reg(REG_GRID_SPACING, 31'd65536);
        write_reg(REG_TIME_STEP, 31'd0);
        send_one(0, 0, 0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_one(17, 42, 9, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678);
        send_random(8);
        drain();
    endtask

    task automatic test_fine_spacing();
        write_reg(REG_GRID_SPACING, 31'd1);
        write_reg(REG_TIME_STEP, 31'd3000);
        send_random(10);
        drain();
        write_reg(REG_GRID_SPACING, 31'd40000);
        write_reg(REG_TIME_STEP, 31'd9000);
        send_random(30);
        drain();
    endtask

    task automatic test_zero_spacing();
        write_reg(REG_GRID_SPACING, 31'd0);
        send_one(10, 10, 10, 32'hFFFF_0000, 32'h0, 32'h0);
        send_random(4);
        drain();
    endtask

    task automatic test_random_mix();
        write_reg(REG_GRID_SPACING, 31'd65536);
        write_reg(REG_TIME_STEP, 31'd6554);
        send_random(30);
        idle_en = 1'b0;
        send_random(20);
        drain();
    endtask

    always @(posedge clk)
    begin
        weight_item_t w;
        if (res_if.valid && res_if.ready)
        begin
            if (pending_weights.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result index %0d weight %0d", $time,
                         res_if.neighbour_index, res_if.weight);
            end
            else
            begin
                w = pending_weights.pop_front();
                if (res_if.neighbour_index !== w.index)
                begin
                    errors++;
                    $display("%0t neighbour_index expected %0d actual %0d", $time,
                             w.index, res_if.neighbour_index);
                end
                if (res_if.weight !== w.weight)
                begin
                    errors++;
                    $display("%0t weight expected %0d actual %0d", $time, w.weight, res_if.weight);
                end
                if (res_if.outside_grid !== w.outside)
                begin
                    errors++;
                    $display("%0t outside_grid expected %0b actual %0b", $time,
                             w.outside, res_if.outside_grid);
                end
                if (res_if.last !== w.last)
                begin
                    errors++;
                    $display("%0t last expected %0b actual %0b", $time, w.last, res_if.last);
                end
            end
        end
        if (rx_stall > 0)
            rx_stall <= rx_stall - 1;
        else if (idle_en && $urandom_range(0, 5) == 0)
            rx_stall <= $urandom_range(1, 3);
        res_if.ready <= !(rx_stall > 1 || (rx_stall == 0 && idle_en && $urandom_range(0, 5) == 0));
    end

    always @(posedge clk)
    begin
        if ((res_if.valid && res_if.ready) || (item_if.valid && item_if.ready)
            || (cfg_if.valid && cfg_if.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        idle_en = 1'b1;
        errors = 0;
        quiet_cycles = 0;
        rx_stall = 0;
        spacing_q = 64'(GRID_SPACING_RST);
        step_q = 64'(TIME_STEP_RST);
        item_if.valid = 1'b0;
        item_if.cell_x = '0;
        item_if.cell_y = '0;
        item_if.cell_z = '0;
        item_if.vel_x = '0;
        item_if.vel_y = '0;
        item_if.vel_z = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        res_if.ready = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_unit_step();
        test_extreme_registers();
        test_zero_step();
        test_fine_spacing();
        test_zero_spacing();
        test_random_mix();
        repeat (50) @(posedge clk);
        if (errors == 0 && pending_weights.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
